>>> design/bltk_pkg.sv
// ----------------------------------------------------------------------------
// bltk_pkg - shared types and constants for the branching literal list
// Field widths, operation codes and the packed list entry.
// ----------------------------------------------------------------------------
`default_nettype none

package bltk_pkg;

  localparam int OP_W     = 2;
  localparam int VAR_W    = 16;
  localparam int CNT_IN_W = 8;
  localparam int SHIFT_W  = 4;
  localparam int CAP_W    = 7;
  localparam int LIT_W    = 17;
  localparam int COST_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_OFFER = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_CAPACITY = 2'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd10;

  typedef logic [COST_W-1:0] cost_t;

  typedef struct packed {
    logic [LIT_W-1:0] lit;
    cost_t            cost;
  } entry_t;

endpackage

`default_nettype wire

>>> design/bltk_score.sv
// ----------------------------------------------------------------------------
// bltk_score - two-stage branching cost unit
// Registers pos*neg and pos+neg, then adds the shifted product to the sum
// in a second register that drives the cost.
// ----------------------------------------------------------------------------
`default_nettype none

module bltk_score (
  input  wire logic                            clk,
  input  wire logic [bltk_pkg::CNT_IN_W-1:0]   pos,
  input  wire logic [bltk_pkg::CNT_IN_W-1:0]   neg,
  input  wire logic [bltk_pkg::SHIFT_W-1:0]    shift,
  output bltk_pkg::cost_t                      cost
);
  import bltk_pkg::*;

  logic [2*CNT_IN_W-1:0] prod_r, prod_nxt;
  logic [CNT_IN_W:0]     sum_r, sum_nxt;
  cost_t                 cost_r, cost_nxt;

  always_comb begin
    prod_nxt = pos * neg;
    sum_nxt  = {1'b0, pos} + {1'b0, neg};
    cost_nxt = COST_W'(sum_r) + (COST_W'(prod_r) << shift);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    cost_r <= cost_nxt;
  end

  assign cost = cost_r;

endmodule

`default_nettype wire

>>> design/branch_literal_top_k_list.sv
// ----------------------------------------------------------------------------
// branch_literal_top_k_list - top-k branching literal list
// Scores offered SAT variables and keeps the best literals in a descending
// list held in a single-port-read memory; a dump streams the list out.
// ----------------------------------------------------------------------------
// Timing: a clear, a skipped offer and an unused operation are done in the
// idle state. An accepted offer goes through the two-stage cost unit and a
// decision state, then a read and a compare state per entry scanned to find
// its slot and a read and a write state per entry moved down to open it,
// then writes the entry and, on a full list, reads back the last entry to
// refresh the lowest cost; a list longer than the capacity is first cut.
// Every read of the list goes through the one read port of the list memory.
// A dump takes a read and an output state per entry and waits while the
// result side stalls. in_stall is high for the whole time an item is at
// work; configuration is always ready.
`default_nettype none

module branch_literal_top_k_list #(
  parameter int LIST_DEPTH = 64,
  parameter int VAR_BITS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bltk_pkg::OP_W-1:0]         in_operation,
  input  wire logic [bltk_pkg::VAR_W-1:0]        in_var_index,
  input  wire logic                              in_var_open,
  input  wire logic [bltk_pkg::CNT_IN_W-1:0]     in_pos_count,
  input  wire logic [bltk_pkg::CNT_IN_W-1:0]     in_neg_count,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bltk_pkg::LIT_W-1:0]             out_literal_out,
  output logic [bltk_pkg::COST_W-1:0]            out_cost_out,
  output logic                                   out_list_empty,
  output logic                                   out_last_entry,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bltk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bltk_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bltk_pkg::*;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SC1      = 4'd1;
  localparam logic [3:0] S_SC2      = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_CUT      = 4'd4;
  localparam logic [3:0] S_FIND_RD  = 4'd5;
  localparam logic [3:0] S_FIND_CMP = 4'd6;
  localparam logic [3:0] S_SH_RD    = 4'd7;
  localparam logic [3:0] S_SH_WR    = 4'd8;
  localparam logic [3:0] S_POST_RD  = 4'd9;
  localparam logic [3:0] S_POST_CMP = 4'd10;
  localparam logic [3:0] S_DUMP_RD  = 4'd11;
  localparam logic [3:0] S_DUMP_OUT = 4'd12;

  // control state
  logic [3:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  cost_t              highest_r, highest_nxt;
  cost_t              lowest_r, lowest_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic               out_valid_r, out_valid_nxt;

  // working registers
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    top_r, top_nxt;
  logic [CNT_W-1:0]    lim_r, lim_nxt;
  logic                full_r, full_nxt;
  logic [CNT_IN_W-1:0] op_pos_r, op_pos_nxt;
  logic [CNT_IN_W-1:0] op_neg_r, op_neg_nxt;
  logic [LIT_W-1:0]    lit_r, lit_nxt;
  logic [LIT_W-1:0]    out_lit_r, out_lit_nxt;
  cost_t               out_cost_r, out_cost_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_last_r, out_last_nxt;

  // list memory
  entry_t             list_mem [LIST_DEPTH];
  entry_t             rdata_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;

  cost_t              score_cost;
  logic [CNT_W-1:0]   cap_eff;
  logic [CNT_W-1:0]   cap_last;
  logic [CNT_W-1:0]   k_prev;
  logic [VAR_W-1:0]   var_m;
  logic               in_acc;
  logic               out_free;
  entry_t             new_entry;

  bltk_score u_score (
    .clk   (clk),
    .pos   (op_pos_r),
    .neg   (op_neg_r),
    .shift (shift_r),
    .cost  (score_cost)
  );

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_r > CAP_W'(LIST_DEPTH)) begin
      cap_eff = CNT_W'(LIST_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
    cap_last = cap_eff - 1'b1;
    k_prev   = k_r - 1'b1;
    for (int i = 0; i < VAR_W; i++) begin
      var_m[i] = in_var_index[i] & (i < VAR_BITS);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign new_entry = '{lit: lit_r, cost: score_cost};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    highest_nxt   = highest_r;
    lowest_nxt    = lowest_r;
    shift_nxt     = shift_r;
    cap_nxt       = cap_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    top_nxt       = top_r;
    lim_nxt       = lim_r;
    full_nxt      = full_r;
    op_pos_nxt    = op_pos_r;
    op_neg_nxt    = op_neg_r;
    lit_nxt       = lit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_lit_nxt   = out_lit_r;
    out_cost_nxt  = out_cost_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = new_entry;
    mem_raddr     = '0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRODUCT_SHIFT: shift_nxt = cfg_data[SHIFT_W-1:0];
        REG_LIST_CAPACITY: cap_nxt   = cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_operation)
            OP_CLEAR: begin
              count_nxt   = '0;
              highest_nxt = '0;
              lowest_nxt  = '0;
            end
            OP_OFFER: begin
              op_pos_nxt = in_pos_count;
              op_neg_nxt = in_neg_count;
              lit_nxt    = {var_m, (in_pos_count > in_neg_count)};
              if (in_var_open && (in_pos_count != '0 || in_neg_count != '0)) begin
                state_nxt = S_SC1;
              end
            end
            OP_DUMP: begin
              k_nxt     = '0;
              state_nxt = S_DUMP_RD;
            end
            default: ;
          endcase
        end
      end
      S_SC1: state_nxt = S_SC2;
      S_SC2: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (count_r > cap_eff) begin
          mem_raddr = cap_last[IDX_W-1:0];
          state_nxt = S_CUT;
        end else if (count_r < cap_eff) begin
          if (score_cost >= highest_r) begin
            pos_nxt   = '0;
            k_nxt     = count_r;
            full_nxt  = 1'b0;
            count_nxt = count_r + 1'b1;
            if (score_cost > highest_r) begin
              highest_nxt = score_cost;
              if (count_r == '0) begin
                lowest_nxt = score_cost;
              end
            end
            state_nxt = S_SH_RD;
          end else if (score_cost <= lowest_r) begin
            mem_we     = 1'b1;
            mem_waddr  = count_r[IDX_W-1:0];
            count_nxt  = count_r + 1'b1;
            lowest_nxt = score_cost;
            state_nxt  = S_IDLE;
          end else begin
            k_nxt     = '0;
            lim_nxt   = count_r;
            top_nxt   = count_r;
            full_nxt  = 1'b0;
            count_nxt = count_r + 1'b1;
            state_nxt = S_FIND_RD;
          end
        end else begin
          if (score_cost < lowest_r) begin
            state_nxt = S_IDLE;
          end else if (score_cost == lowest_r) begin
            mem_we    = 1'b1;
            mem_waddr = cap_last[IDX_W-1:0];
            state_nxt = S_IDLE;
          end else if (score_cost >= highest_r) begin
            pos_nxt     = '0;
            k_nxt       = cap_last;
            full_nxt    = 1'b1;
            highest_nxt = score_cost;
            state_nxt   = S_SH_RD;
          end else begin
            k_nxt     = '0;
            lim_nxt   = cap_eff;
            top_nxt   = cap_last;
            full_nxt  = 1'b1;
            state_nxt = S_FIND_RD;
          end
        end
      end
      S_CUT: begin
        count_nxt  = cap_eff;
        lowest_nxt = rdata_r.cost;
        state_nxt  = S_DECIDE;
      end
      S_FIND_RD: begin
        if (k_r == lim_r) begin
          pos_nxt   = k_r;
          k_nxt     = top_r;
          state_nxt = S_SH_RD;
        end else begin
          mem_raddr = k_r[IDX_W-1:0];
          state_nxt = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (rdata_r.cost > score_cost) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_FIND_RD;
        end else begin
          pos_nxt   = k_r;
          k_nxt     = top_r;
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (k_r == pos_r) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[IDX_W-1:0];
          state_nxt = full_r ? S_POST_RD : S_IDLE;
        end else begin
          mem_raddr = k_prev[IDX_W-1:0];
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[IDX_W-1:0];
        mem_wdata = rdata_r;
        k_nxt     = k_prev;
        state_nxt = S_SH_RD;
      end
      S_POST_RD: begin
        mem_raddr = cap_last[IDX_W-1:0];
        state_nxt = S_POST_CMP;
      end
      S_POST_CMP: begin
        if (rdata_r.cost > lowest_r) begin
          lowest_nxt = rdata_r.cost;
        end
        state_nxt = S_IDLE;
      end
      S_DUMP_RD: begin
        mem_raddr = k_r[IDX_W-1:0];
        state_nxt = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        // keep the current entry on the read port while the output waits
        mem_raddr = k_r[IDX_W-1:0];
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_lit_nxt   = '0;
            out_cost_nxt  = '0;
            out_empty_nxt = 1'b1;
            out_last_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            out_lit_nxt   = rdata_r.lit;
            out_cost_nxt  = rdata_r.cost;
            out_empty_nxt = 1'b0;
            out_last_nxt  = (k_r + 1'b1 == count_r);
            if (k_r + 1'b1 == count_r) begin
              state_nxt = S_IDLE;
            end else begin
              k_nxt     = k_r + 1'b1;
              state_nxt = S_DUMP_RD;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      highest_r   <= '0;
      lowest_r    <= '0;
      shift_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      highest_r   <= highest_nxt;
      lowest_r    <= lowest_nxt;
      shift_r     <= shift_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    pos_r       <= pos_nxt;
    top_r       <= top_nxt;
    lim_r       <= lim_nxt;
    full_r      <= full_nxt;
    op_pos_r    <= op_pos_nxt;
    op_neg_r    <= op_neg_nxt;
    lit_r       <= lit_nxt;
    out_lit_r   <= out_lit_nxt;
    out_cost_r  <= out_cost_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  // list memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      list_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= list_mem[mem_raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_literal_out = out_lit_r;
  assign out_cost_out    = out_cost_r;
  assign out_list_empty  = out_empty_r;
  assign out_last_entry  = out_last_r;

endmodule

`default_nettype wire
